/* rtl/greedy_nearest_worker_match_defines.svh */
// Assertion macros for the greedy nearest worker matcher.
// No dependencies; included by the modules that carry assertions.
`ifndef GREEDY_NEAREST_WORKER_MATCH_DEFINES_SVH
`define GREEDY_NEAREST_WORKER_MATCH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GNWM_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define GNWM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/gnwm_pkg.sv */
// Shared types and constants for the greedy nearest worker matcher.
// No dependencies.
package gnwm_pkg;

   localparam int MAX_WORKERS_DEF = 1024;
   localparam int COORD_BITS      = 16;
   localparam int TIME_BITS       = 32;
   localparam int OP_BITS         = 2;
   localparam int IDX_OUT_BITS    = 10;
   localparam int DIST_BITS       = 2 * COORD_BITS + 1;
   localparam int REQ_DATA_BITS   = 2 * COORD_BITS + TIME_BITS;
   localparam int RSP_DATA_BITS   = ((DIST_BITS + IDX_OUT_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS    = RSP_DATA_BITS - DIST_BITS - IDX_OUT_BITS;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD  = 2'd0,
      OP_MATCH = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;     // store worker from request
      logic clear;    // empty the store
      logic start;    // latch task, reset scan
      logic scan_en;  // step the scan
      logic finish;   // commit winner, load response
   } cmd_type;

   typedef struct packed {
      logic scan_busy;  // entries left or still in flight
      logic rsp_free;   // response register can take a new result
   } sts_type;

endpackage

/* rtl/gnwm_ctrl.sv */
// Controller state machine for the greedy nearest worker matcher.
// Depends on gnwm_pkg.
module gnwm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic [gnwm_pkg::OP_BITS-1:0]  req_tuser,
   output logic                          req_tready,
   output gnwm_pkg::cmd_type             cmd,
   input  gnwm_pkg::sts_type             sts
);
   import gnwm_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_tvalid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_tuser == OP_MATCH)) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!sts.scan_busy) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_tuser)
                  OP_LOAD:  cmd.load  = 1'b1;
                  OP_MATCH: cmd.start = 1'b1;
                  OP_CLEAR: cmd.clear = 1'b1;
                  default:  ;  // unused code, dropped
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = sts.rsp_free;
         end
         default: ;
      endcase
   end

endmodule

/* rtl/gnwm_datapath.sv */
// Worker store, scan pipeline, best tracker and response register.
// Depends on gnwm_pkg and greedy_nearest_worker_match_defines.svh.
`include "greedy_nearest_worker_match_defines.svh"

module gnwm_datapath #(
   parameter int MAX_WORKERS = gnwm_pkg::MAX_WORKERS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gnwm_pkg::cmd_type                   cmd,
   output gnwm_pkg::sts_type                   sts,
   input  logic [gnwm_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic                                rsp_tuser,
   output logic [gnwm_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import gnwm_pkg::*;

   localparam int IW         = $clog2(MAX_WORKERS);
   localparam int CW         = $clog2(MAX_WORKERS + 1);
   localparam int ENTRY_BITS = 2 * COORD_BITS + TIME_BITS;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_WORKERS);

   // entry layout {time, y, x}
   logic [ENTRY_BITS-1:0] entry_mem [MAX_WORKERS];
   logic                  flag_mem  [MAX_WORKERS];

   logic [COORD_BITS-1:0] in_x, in_y;
   logic [TIME_BITS-1:0]  in_t;

   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         addr_ff, addr_in;
   logic                  stop_ff, stop_in;
   logic                  have_ff, have_in;
   logic                  v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [COORD_BITS-1:0] task_x_ff, task_y_ff;
   logic [TIME_BITS-1:0]  task_t_ff;
   logic [ENTRY_BITS-1:0] rd_entry_ff;
   logic                  rd_flag_ff;
   logic [IW-1:0]         idx1_ff, idx2_ff, idx3_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [SQ_BITS-1:0]    sqx_ff, sqy_ff;
   logic [IW-1:0]         best_idx_ff;
   logic [DIST_BITS-1:0]  best_d_ff;
   logic                  rsp_found_ff;
   logic [IDX_OUT_BITS-1:0] rsp_idx_ff;
   logic [DIST_BITS-1:0]  rsp_dist_ff;

   logic                  load_ok, issue, brk_now, pass1, take;
   logic [IW-1:0]         addr_idx, count_idx;
   logic [COORD_BITS-1:0] rd_x, rd_y;
   logic [TIME_BITS-1:0]  rd_t;
   logic [COORD_BITS:0]   diff_x, diff_y, abs_x, abs_y;
   logic [SQ_BITS-1:0]    dx_wide, dy_wide;
   logic [DIST_BITS-1:0]  dist_now;
   logic [IW+IDX_OUT_BITS-1:0] best_wide;

   assign in_x = req_tdata[COORD_BITS-1:0];
   assign in_y = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign in_t = req_tdata[REQ_DATA_BITS-1:2*COORD_BITS];

   assign addr_idx  = addr_ff[IW-1:0];
   assign count_idx = count_ff[IW-1:0];
   assign load_ok   = cmd.load && (count_ff < MAX_COUNT);

   // stage 1: registered store read
   assign rd_x = rd_entry_ff[COORD_BITS-1:0];
   assign rd_y = rd_entry_ff[2*COORD_BITS-1:COORD_BITS];
   assign rd_t = rd_entry_ff[ENTRY_BITS-1:2*COORD_BITS];

   // first unmatched worker that arrived after the task ends the scan
   assign brk_now = v1_ff && !rd_flag_ff && (rd_t > task_t_ff);
   assign pass1   = v1_ff && !rd_flag_ff && !brk_now;
   assign issue   = cmd.scan_en && !stop_ff && !brk_now && (addr_ff < count_ff);

   assign diff_x = {rd_x[COORD_BITS-1], rd_x} - {task_x_ff[COORD_BITS-1], task_x_ff};
   assign diff_y = {rd_y[COORD_BITS-1], rd_y} - {task_y_ff[COORD_BITS-1], task_y_ff};
   assign abs_x  = diff_x[COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
   assign abs_y  = diff_y[COORD_BITS] ? (~diff_y + 1'b1) : diff_y;
   assign dx_in  = abs_x[COORD_BITS-1:0];
   assign dy_in  = abs_y[COORD_BITS-1:0];

   // stage 3 products, stage 4 sum and compare
   assign dx_wide  = SQ_BITS'(dx_ff);
   assign dy_wide  = SQ_BITS'(dy_ff);
   assign dist_now = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   // strict less-than keeps the earliest worker on a tie
   assign take     = v3_ff && (!have_ff || (dist_now < best_d_ff));

   assign best_wide = {{IDX_OUT_BITS{1'b0}}, best_idx_ff};

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (load_ok) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      addr_in = addr_ff;
      stop_in = stop_ff;
      have_in = have_ff;
      if (cmd.start) begin
         addr_in = '0;
         stop_in = 1'b0;
         have_in = 1'b0;
      end else begin
         if (issue) addr_in = addr_ff + 1'b1;
         if (brk_now) stop_in = 1'b1;
         if (take) have_in = 1'b1;
      end
   end

   assign v1_in = issue;
   assign v2_in = pass1;
   assign v3_in = v2_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         addr_ff      <= '0;
         stop_ff      <= 1'b0;
         have_ff      <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         stop_ff      <= stop_in;
         have_ff      <= have_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // worker store
   always_ff @(posedge clock) begin
      if (load_ok) begin
         entry_mem[count_idx] <= {in_t, in_y, in_x};
      end
      rd_entry_ff <= entry_mem[addr_idx];
   end

   // matched flags: cleared on load, so no clearing pass is needed
   always_ff @(posedge clock) begin
      if (load_ok) begin
         flag_mem[count_idx] <= 1'b0;
      end else if (cmd.finish && have_ff) begin
         flag_mem[best_idx_ff] <= 1'b1;
      end
      rd_flag_ff <= flag_mem[addr_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         task_x_ff <= in_x;
         task_y_ff <= in_y;
         task_t_ff <= in_t;
      end
      idx1_ff <= addr_idx;
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      sqx_ff  <= dx_wide * dx_wide;
      sqy_ff  <= dy_wide * dy_wide;
      if (take) begin
         best_idx_ff <= idx3_ff;
         best_d_ff   <= dist_now;
      end
      if (cmd.finish) begin
         rsp_found_ff <= have_ff;
         rsp_idx_ff   <= have_ff ? best_wide[IDX_OUT_BITS-1:0] : '0;
         rsp_dist_ff  <= have_ff ? best_d_ff : '0;
      end
   end

   assign sts.scan_busy = v1_ff || v2_ff || v3_ff || (!stop_ff && (addr_ff < count_ff));
   assign sts.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, rsp_dist_ff, rsp_idx_ff};

   `GNWM_ASSERT_NEXT(a_no_issue_after_stop, clock, reset, v1_ff && brk_now, !v1_ff, "read issued past the stopping worker")
   `GNWM_ASSERT_NOW(a_finish_drained, clock, reset, cmd.finish, !(v1_ff || v2_ff || v3_ff), "result committed with scan entries in flight")
   `GNWM_ASSERT_NOW(a_winner_loaded, clock, reset, cmd.finish && have_ff, CW'(best_idx_ff) < count_ff, "winner index beyond loaded workers")
   `GNWM_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= MAX_COUNT, "worker count beyond capacity")

endmodule

/* rtl/greedy_nearest_worker_match.sv */
// Top level of the greedy nearest worker matcher: controller plus datapath.
// Depends on gnwm_pkg, gnwm_ctrl and gnwm_datapath.
//
//   channel  dir  tdata fields (low bit up)                tuser
//   req_     in   pos_x[15:0] pos_y[31:16] arrival[63:32]   operation[1:0]
//   rsp_     out  worker_index[9:0] dist_sq[42:10] pad      found
//
// A match scans up to MAX_WORKERS workers in order, from the first worker loaded:
// the worker store has one read port
// and the scan steps one entry per cycle through a four stage distance pipe.
// Reset clears only control state; each matched flag is rewritten when its
// worker is loaded, so no clearing pass runs. A finished result waits in the
// output register; loads and clears are transferred meanwhile, and a new match
// scans, then holds until that register frees.
module greedy_nearest_worker_match #(
   parameter int MAX_WORKERS = gnwm_pkg::MAX_WORKERS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pos_x, pos_y, arrival_time
   input  logic [gnwm_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // operation
   input  logic [gnwm_pkg::OP_BITS-1:0]        req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // worker_index, distance_squared, zero pad
   output logic [gnwm_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // found
   output logic                                rsp_tuser
);
   import gnwm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   gnwm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   gnwm_datapath #(
      .MAX_WORKERS (MAX_WORKERS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
